/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL; compiled out when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: whenever a holds, b holds too
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication: whenever a holds, b holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, a, b)
`define ASSERT_NEXT(lbl, clk, rst_n, a, b)

`endif

`endif

/* src/qrv_pkg.sv */
// ----------------------------------------------------------------------------
// qrv_pkg
// Widths, register indexes and rounding helpers for the quaternion
// vector rotation pipeline.
// ----------------------------------------------------------------------------
package qrv_pkg;

    // Vector data width (range 8 .. 32)
    localparam int DATA_WIDTH = 16;

    // Quaternion components: signed Q1.14
    localparam int QW = 16;
    // Fraction bits of the exact rotated sum (two Q1.14 factors)
    localparam int QFRAC = 28;

    // Quaternion product width, matrix entry width
    localparam int PW = 2 * QW;
    localparam int MW = PW + 2;
    // Matrix entry times vector component
    localparam int PRW = MW + DATA_WIDTH;
    // Sum of three products
    localparam int SW = PRW + 2;
    // Integer part after dropping the fraction
    localparam int RW = SW - QFRAC;

    // Configuration port
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = CFG_IDX_W'(3);

    // Reset quaternion is the identity (1.0 in Q1.14)
    localparam logic signed [QW-1:0] QUAT_W_RESET = QW'(16384);
    localparam logic signed [QW-1:0] QUAT_ZERO    = '0;

    // Half an LSB of the result, for round to nearest (ties up)
    localparam logic signed [SW-1:0] ROUND_BIAS =
        {{(SW-QFRAC){1'b0}}, 1'b1, {(QFRAC-1){1'b0}}};

    // Output limits
    localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Clamp the integer part to the output range
    function automatic logic signed [DATA_WIDTH-1:0] sat_out(
        input logic signed [RW-1:0] v
    );
        logic signed [DATA_WIDTH-1:0] r;
        if (v > RW'(DMAX))
            r = DMAX;
        else if (v < RW'(DMIN))
            r = DMIN;
        else
            r = v[DATA_WIDTH-1:0];
        return r;
    endfunction

endpackage

/* src/quaternion_rotate_vector.sv */
// ----------------------------------------------------------------------------
// quaternion_rotate_vector
// Rotates a stream of 3-vectors by the quaternion held in four registers.
// ----------------------------------------------------------------------------
// Each vector (vec_x, vec_y, vec_z) is rotated by q * v * conj(q), where q is
// the signed Q1.14 quaternion in registers quat_w, quat_x, quat_y, quat_z
// (index 0..3 on the cfg port; other indexes are ignored; reset value is the
// identity). A non-unit q scales the result by its squared norm. The exact
// sum is rounded to nearest (ties toward +inf) and saturated. Throughput is
// one vector per clock when the output does not stall; a vector passes the
// five register stages on its way to rot_valid: quaternion products, rotation
// matrix, nine matrix-by-component multiplies, three-term sums with rounding
// bias, and saturation into the output register. Registers may only be
// written while no vector is in flight; cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_rotate_vector
    import qrv_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,

    // Configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [QW-1:0]                cfg_data,

    // Vector input channel
    input  logic                         vec_valid,
    output logic                         vec_ready,
    input  logic signed [DATA_WIDTH-1:0] vec_x,
    input  logic signed [DATA_WIDTH-1:0] vec_y,
    input  logic signed [DATA_WIDTH-1:0] vec_z,

    // Rotated vector output channel
    output logic                         rot_valid,
    input  logic                         rot_ready,
    output logic signed [DATA_WIDTH-1:0] rot_x,
    output logic signed [DATA_WIDTH-1:0] rot_y,
    output logic signed [DATA_WIDTH-1:0] rot_z
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [QW-1:0] quat_w_reg, quat_x_reg, quat_y_reg, quat_z_reg;
    logic                 cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_w_reg <= QUAT_W_RESET;
            quat_x_reg <= QUAT_ZERO;
            quat_y_reg <= QUAT_ZERO;
            quat_z_reg <= QUAT_ZERO;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_QUAT_W: quat_w_reg <= cfg_data;
                REG_QUAT_X: quat_x_reg <= cfg_data;
                REG_QUAT_Y: quat_y_reg <= cfg_data;
                REG_QUAT_Z: quat_z_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valids and enables (each stage advances when it is empty or
    // its successor advances)
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s1_en, s2_en, s3_en, s4_en, s5_en;

    assign s5_en     = !s5_valid_reg || rot_ready;
    assign s4_en     = !s4_valid_reg || s5_en;
    assign s3_en     = !s3_valid_reg || s4_en;
    assign s2_en     = !s2_valid_reg || s3_en;
    assign s1_en     = !s1_valid_reg || s2_en;
    assign vec_ready = s1_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en) s1_valid_reg <= vec_valid;
            if (s2_en) s2_valid_reg <= s1_valid_reg;
            if (s3_en) s3_valid_reg <= s2_valid_reg;
            if (s4_en) s4_valid_reg <= s3_valid_reg;
            if (s5_en) s5_valid_reg <= s4_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: quaternion products, vector capture
    // ------------------------------------------------------------------
    logic signed [PW-1:0]         ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PW-1:0]         xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic signed [PW-1:0]         ww_next, xx_next, yy_next, zz_next;
    logic signed [PW-1:0]         xy_next, xz_next, yz_next, wx_next, wy_next, wz_next;
    logic signed [DATA_WIDTH-1:0] v1_reg [3];
    logic signed [DATA_WIDTH-1:0] v1_next [3];

    always_comb
    begin
        ww_next = PW'(quat_w_reg) * PW'(quat_w_reg);
        xx_next = PW'(quat_x_reg) * PW'(quat_x_reg);
        yy_next = PW'(quat_y_reg) * PW'(quat_y_reg);
        zz_next = PW'(quat_z_reg) * PW'(quat_z_reg);
        xy_next = PW'(quat_x_reg) * PW'(quat_y_reg);
        xz_next = PW'(quat_x_reg) * PW'(quat_z_reg);
        yz_next = PW'(quat_y_reg) * PW'(quat_z_reg);
        wx_next = PW'(quat_w_reg) * PW'(quat_x_reg);
        wy_next = PW'(quat_w_reg) * PW'(quat_y_reg);
        wz_next = PW'(quat_w_reg) * PW'(quat_z_reg);
        v1_next[0] = vec_x;
        v1_next[1] = vec_y;
        v1_next[2] = vec_z;
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && vec_valid)
        begin
            ww_reg <= ww_next;
            xx_reg <= xx_next;
            yy_reg <= yy_next;
            zz_reg <= zz_next;
            xy_reg <= xy_next;
            xz_reg <= xz_next;
            yz_reg <= yz_next;
            wx_reg <= wx_next;
            wy_reg <= wy_next;
            wz_reg <= wz_next;
            v1_reg <= v1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: rotation matrix entries (Q2.28)
    // ------------------------------------------------------------------
    logic signed [MW-1:0]         m_reg  [3][3];
    logic signed [MW-1:0]         m_next [3][3];
    logic signed [DATA_WIDTH-1:0] v2_reg [3];

    always_comb
    begin
        m_next[0][0] = MW'(ww_reg) + MW'(xx_reg) - MW'(yy_reg) - MW'(zz_reg);
        m_next[0][1] = (MW'(xy_reg) - MW'(wz_reg)) <<< 1;
        m_next[0][2] = (MW'(xz_reg) + MW'(wy_reg)) <<< 1;
        m_next[1][0] = (MW'(xy_reg) + MW'(wz_reg)) <<< 1;
        m_next[1][1] = MW'(ww_reg) - MW'(xx_reg) + MW'(yy_reg) - MW'(zz_reg);
        m_next[1][2] = (MW'(yz_reg) - MW'(wx_reg)) <<< 1;
        m_next[2][0] = (MW'(xz_reg) - MW'(wy_reg)) <<< 1;
        m_next[2][1] = (MW'(yz_reg) + MW'(wx_reg)) <<< 1;
        m_next[2][2] = MW'(ww_reg) - MW'(xx_reg) - MW'(yy_reg) + MW'(zz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s2_en && s1_valid_reg)
        begin
            m_reg  <= m_next;
            v2_reg <= v1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: nine matrix-by-component products
    // ------------------------------------------------------------------
    logic signed [PRW-1:0] prod_reg  [3][3];
    logic signed [PRW-1:0] prod_next [3][3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[r][c] = PRW'(m_reg[r][c]) * PRW'(v2_reg[c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_en && s2_valid_reg)
            prod_reg <= prod_next;
    end

    // ------------------------------------------------------------------
    // Stage 4: row sums plus rounding bias
    // ------------------------------------------------------------------
    logic signed [SW-1:0] sum_reg  [3];
    logic signed [SW-1:0] sum_next [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum_next[r] = SW'(prod_reg[r][0]) + SW'(prod_reg[r][1])
                        + SW'(prod_reg[r][2]) + ROUND_BIAS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_en && s3_valid_reg)
            sum_reg <= sum_next;
    end

    // ------------------------------------------------------------------
    // Stage 5: drop the fraction, saturate, output register
    // ------------------------------------------------------------------
    logic signed [DATA_WIDTH-1:0] rot_reg  [3];
    logic signed [DATA_WIDTH-1:0] rot_next [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            rot_next[r] = sat_out(sum_reg[r][SW-1:QFRAC]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s5_en && s4_valid_reg)
            rot_reg <= rot_next;
    end

    assign rot_valid = s5_valid_reg;
    assign rot_x     = rot_reg[0];
    assign rot_y     = rot_reg[1];
    assign rot_z     = rot_reg[2];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A full pipeline behind a stalled output refuses new vectors
    `ASSERT_IMPLIES(a_full_stall, clk, rst_n, s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg && s5_valid_reg && !rot_ready, !vec_ready)
    // An accepted vector always lands in stage 1
    `ASSERT_NEXT(a_accept_fill, clk, rst_n, vec_valid && vec_ready, s1_valid_reg)
    // A finished sum moves to an empty output register
    `ASSERT_NEXT(a_drain, clk, rst_n, s4_valid_reg && !s5_valid_reg, rot_valid)

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion rotation testbench
// Drives vectors through quaternion_rotate_vector under several quaternion
// settings and idle patterns. A scoreboard predicts each rotated, rounded
// and saturated vector and checks the outputs in order.
// ----------------------------------------------------------------------------
module testbench;
    import qrv_pkg::*;

    localparam int LIMIT_CYCLES    = 200000;
    localparam int SETTLE_CYCLES   = 12;
    localparam int RESET_CYCLES    = 7;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int RANDOM_PHASES   = 12;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] x;
        logic signed [DATA_WIDTH-1:0] y;
        logic signed [DATA_WIDTH-1:0] z;
    } vec3_t;

    // ------------------------------------------------------------------------
    // Scoreboard: quaternion copy, rotation predictor, expected-vector queue
    // ------------------------------------------------------------------------
    class rotation_scoreboard;
        logic signed [QW-1:0] qw;
        logic signed [QW-1:0] qx;
        logic signed [QW-1:0] qy;
        logic signed [QW-1:0] qz;
        vec3_t rotated_q[$];
        int    error_count;

        function new();
            qw = QUAT_W_RESET;
            qx = QUAT_ZERO;
            qy = QUAT_ZERO;
            qz = QUAT_ZERO;
            error_count = 0;
        endfunction

        // Register write seen on the cfg port; unknown indexes are dropped
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [QW-1:0] data);
            case (idx)
                REG_QUAT_W: qw = data;
                REG_QUAT_X: qx = data;
                REG_QUAT_Y: qy = data;
                REG_QUAT_Z: qz = data;
                default: ;
            endcase
        endfunction

        // One row of the rotation matrix times v, rounded (ties up), saturated
        function logic signed [DATA_WIDTH-1:0] row_dot(longint m0, longint m1,
                                                       longint m2, vec3_t v);
            longint acc;
            logic signed [DATA_WIDTH-1:0] r;
            acc = m0 * longint'(v.x) + m1 * longint'(v.y) + m2 * longint'(v.z);
            acc = acc + (longint'(1) <<< (QFRAC - 1));
            acc = acc >>> QFRAC;
            if (acc > longint'(DMAX))
                r = DMAX;
            else if (acc < longint'(DMIN))
                r = DMIN;
            else
                r = acc[DATA_WIDTH-1:0];
            return r;
        endfunction

        // Expected q * v * conj(q) for an accepted vector
        function void note_vector(vec3_t v);
            longint w, x, y, z;
            longint ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
            vec3_t  r;
            w = longint'(qw);
            x = longint'(qx);
            y = longint'(qy);
            z = longint'(qz);
            ww = w * w;  xx = x * x;  yy = y * y;  zz = z * z;
            xy = x * y;  xz = x * z;  yz = y * z;
            wx = w * x;  wy = w * y;  wz = w * z;
            r.x = row_dot(ww + xx - yy - zz, 2 * (xy - wz), 2 * (xz + wy), v);
            r.y = row_dot(2 * (xy + wz), ww - xx + yy - zz, 2 * (yz - wx), v);
            r.z = row_dot(2 * (xz - wy), 2 * (yz + wx), ww - xx - yy + zz, v);
            rotated_q.push_back(r);
        endfunction

        task flag_error(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            error_count++;
        endtask

        // Compare an output transfer with the oldest expectation
        task check_result(vec3_t got);
            vec3_t want;
            if (rotated_q.size() == 0) begin
                flag_error($sformatf("unexpected result (%0d, %0d, %0d)",
                                     got.x, got.y, got.z));
            end
            else begin
                want = rotated_q.pop_front();
                if (got.x !== want.x)
                    flag_error($sformatf("rot_x got %0d want %0d", got.x, want.x));
                if (got.y !== want.y)
                    flag_error($sformatf("rot_y got %0d want %0d", got.y, want.y));
                if (got.z !== want.z)
                    flag_error($sformatf("rot_z got %0d want %0d", got.z, want.z));
            end
        endtask

        function int pending();
            return rotated_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block signals
    // ------------------------------------------------------------------------
    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [QW-1:0]                cfg_data  = '0;
    logic                         vec_valid = 1'b0;
    logic                         vec_ready;
    logic signed [DATA_WIDTH-1:0] vec_x     = '0;
    logic signed [DATA_WIDTH-1:0] vec_y     = '0;
    logic signed [DATA_WIDTH-1:0] vec_z     = '0;
    logic                         rot_valid;
    logic                         rot_ready = 1'b0;
    logic signed [DATA_WIDTH-1:0] rot_x;
    logic signed [DATA_WIDTH-1:0] rot_y;
    logic signed [DATA_WIDTH-1:0] rot_z;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    rotation_scoreboard rot_sb = new();

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    quaternion_rotate_vector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .vec_valid (vec_valid),
        .vec_ready (vec_ready),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .rot_valid (rot_valid),
        .rot_ready (rot_ready),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .rot_z     (rot_z)
    );

    // ------------------------------------------------------------------------
    // Monitors: register writes, input transfers, output transfers
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            rot_sb.write_reg(cfg_index, cfg_data);
    end

    always @(posedge clk)
    begin
        vec3_t v;
        if (rst_n && vec_valid && vec_ready) begin
            v.x = vec_x;
            v.y = vec_y;
            v.z = vec_z;
            rot_sb.note_vector(v);
        end
    end

    always @(posedge clk)
    begin
        vec3_t r;
        if (rst_n && rot_valid && rot_ready) begin
            r.x = rot_x;
            r.y = rot_y;
            r.z = rot_z;
            rot_sb.check_result(r);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Output side: random stalls, plus a long hold-off counted down here
    // ------------------------------------------------------------------------
    initial
    begin
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                rot_ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else begin
                rot_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drive tasks
    // ------------------------------------------------------------------------
    function automatic vec3_t mk_vec(int x, int y, int z);
        vec3_t v;
        v.x = x[DATA_WIDTH-1:0];
        v.y = y[DATA_WIDTH-1:0];
        v.z = z[DATA_WIDTH-1:0];
        return v;
    endfunction

    task automatic send_vector(vec3_t v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            vec_valid <= 1'b0;
            @(posedge clk);
        end
        vec_valid <= 1'b1;
        vec_x     <= v.x;
        vec_y     <= v.y;
        vec_z     <= v.z;
        do @(posedge clk); while (!vec_ready);
    endtask

    // Keeps cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [QW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Stop the stream and wait until every expected vector is out
    task automatic drain();
        vec_valid <= 1'b0;
        @(posedge clk);
        while (rot_sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_stray_reg();
        logic [CFG_IDX_W-1:0] idx;
        idx = CFG_IDX_W'($urandom_range(int'(REG_QUAT_Z) + 1, (1 << CFG_IDX_W) - 1));
        write_reg(idx, QW'($urandom));
    endtask

    // Load all four quaternion registers, sometimes with a stray index mixed in
    task automatic load_quat(int w, int x, int y, int z);
        write_reg(REG_QUAT_W, w[QW-1:0]);
        if ($urandom_range(0, 3) == 0)
            write_stray_reg();
        write_reg(REG_QUAT_X, x[QW-1:0]);
        write_reg(REG_QUAT_Y, y[QW-1:0]);
        if ($urandom_range(0, 3) == 0)
            write_stray_reg();
        write_reg(REG_QUAT_Z, z[QW-1:0]);
        cfg_valid <= 1'b0;
    endtask

    // Quaternion for a random phase: unit, raw bits, small, or scaled unit
    task automatic load_random_quat(int kind);
        real c[4];
        real n;
        real scale;
        int  q[4];
        for (int i = 0; i < 4; i++)
            c[i] = real'($urandom_range(0, 65535)) - 32768.0;
        n = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
        scale = (kind == 3) ? real'($urandom_range(8, 23)) / 16.0 : 1.0;
        for (int i = 0; i < 4; i++) begin
            case (kind)
                1:       q[i] = int'($urandom_range(0, 65535)) - 32768;
                2:       q[i] = int'($urandom_range(0, 4095)) - 2048;
                default: q[i] = (n < 1.0) ? ((i == 0) ? 16384 : 0)
                                          : $rtoi(c[i] / n * 16384.0 * scale);
            endcase
        end
        load_quat(q[0], q[1], q[2], q[3]);
    endtask

    function automatic vec3_t random_vector();
        vec3_t v;
        if ($urandom_range(0, 9) < 7) begin
            v.x = DATA_WIDTH'($urandom);
            v.y = DATA_WIDTH'($urandom);
            v.z = DATA_WIDTH'($urandom);
        end
        else begin
            v = mk_vec(int'($urandom_range(0, 2047)) - 1024,
                       int'($urandom_range(0, 2047)) - 1024,
                       int'($urandom_range(0, 2047)) - 1024);
        end
        return v;
    endfunction

    // Idle patterns: none, sender gaps, receiver stalls, both
    task automatic set_idling(int mode);
        case (mode)
            1:       begin send_idle_pct = 56; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 56; end
            3:       begin send_idle_pct = 24; stall_pct = 24; end
            default: begin send_idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset quaternion is the identity: extremes pass straight through
        set_idling(0);
        send_vector(mk_vec(0, 0, 0));
        send_vector(mk_vec(32767, 32767, 32767));
        send_vector(mk_vec(-32768, -32768, -32768));
        send_vector(mk_vec(32767, -32768, 1));
        send_vector(mk_vec(-1, -1, -1));
        send_vector(mk_vec(1, 0, 0));
        drain();

        // w = 0.5 scales by a quarter: exact ties round toward plus infinity
        load_quat(8192, 0, 0, 0);
        send_vector(mk_vec(2, -2, 6));
        send_vector(mk_vec(-6, 1, -1));
        send_vector(mk_vec(3, 5, -3));
        drain();

        // Most negative quaternion: large norm, large results saturate
        load_quat(-32768, -32768, -32768, -32768);
        send_vector(mk_vec(32767, 32767, 32767));
        send_vector(mk_vec(-32768, 0, 1));
        send_vector(mk_vec(1, 1, 1));
        drain();

        // Most positive quaternion
        load_quat(32767, 32767, 32767, 32767);
        send_vector(mk_vec(1, 2, 3));
        send_vector(mk_vec(-32768, 32767, -32768));
        drain();

        // Quarter turn about z
        load_quat(11585, 0, 0, 11585);
        send_vector(mk_vec(16384, 0, 0));
        send_vector(mk_vec(0, 16384, 0));
        send_vector(mk_vec(0, 0, -32768));
        drain();

        // Writes to indexes past the last register must not disturb anything
        for (int i = int'(REG_QUAT_Z) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), QW'($urandom));
        cfg_valid <= 1'b0;
        send_vector(mk_vec(12345, -23456, 32767));
        send_vector(mk_vec(-32768, 32767, 0));
        drain();

        // Random phases
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            load_random_quat((p + p / 4) % 4);
            set_idling(p % 4);
            // Long output hold-off while the input keeps offering vectors
            if (p == 4 || p == 8)
                hold_left = HOLD_OFF_CYCLES;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_vector(random_vector());
            drain();
        end

        // Back to the identity after reset-value coverage
        load_quat(int'(QUAT_W_RESET), 0, 0, 0);
        set_idling(3);
        for (int i = 0; i < 20; i++)
            send_vector(random_vector());
        drain();

        if (rot_sb.pending() != 0)
            rot_sb.flag_error($sformatf("%0d results never arrived", rot_sb.pending()));

        if (rot_sb.error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
